/* design/apa102_led_frame_encoder_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the LED frame encoder
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef APA102_LED_FRAME_ENCODER_CORE_ASSERT_SVH
`define APA102_LED_FRAME_ENCODER_CORE_ASSERT_SVH

// same-cycle implication
`define APA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define APA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/apa_enc_pkg.sv */
// ----------------------------------------------------------------------------
// apa_enc_pkg
// Types, byte codes and stream positions of the LED frame encoder.
// ----------------------------------------------------------------------------
package apa_enc_pkg;

	typedef logic [3:0] pos_t;
	typedef logic [1:0] cfg_idx_t;

	// byte positions within one item's run
	localparam pos_t POS_START0 = 4'd0;
	localparam pos_t POS_START1 = 4'd1;
	localparam pos_t POS_START2 = 4'd2;
	localparam pos_t POS_START3 = 4'd3;
	localparam pos_t POS_HEADER = 4'd4;
	localparam pos_t POS_COLOR0 = 4'd5;
	localparam pos_t POS_COLOR1 = 4'd6;
	localparam pos_t POS_COLOR2 = 4'd7;
	localparam pos_t POS_END0   = 4'd8;
	localparam pos_t POS_END1   = 4'd9;
	localparam pos_t POS_END2   = 4'd10;
	localparam pos_t POS_END3   = 4'd11;

	localparam cfg_idx_t CFG_COLOR_ORDER       = 2'd0;
	localparam cfg_idx_t CFG_BRIGHTNESS_MODE   = 2'd1;
	localparam cfg_idx_t CFG_GLOBAL_BRIGHTNESS = 2'd2;

	localparam logic [8:0] GLOBAL_BRIGHTNESS_RST = 9'd256;

	localparam logic [7:0] BYTE_START  = 8'h00;
	localparam logic [7:0] BYTE_END    = 8'hFF;
	localparam logic [7:0] HEADER_MARK = 8'hE0;
	localparam logic [4:0] BRIGHT_MAX  = 5'd31;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_led;
	} led_t;

	function automatic logic [4:0] brightness(input logic mode, input logic [8:0] global_val,
		input logic [7:0] alpha);
		logic [4:0] b;
		if (mode) begin
			b = alpha[7:3];
		end else if (global_val[8]) begin
			b = BRIGHT_MAX;
		end else begin
			b = global_val[7:3];
		end
		return b;
	endfunction

endpackage

/* design/apa102_led_frame_encoder_core.sv */
// ----------------------------------------------------------------------------
// apa102_led_frame_encoder_core
// Turns LED items into the byte stream of a four-byte-per-LED LED strip:
// optional start frame, header with brightness, three color bytes,
// optional end frame.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata {alpha,blue,green,red}, tuser first, tlast last
//  m_axis    out  tvalid/tready          tdata byte, tlast end of item, tuser frame done
//  cfg       in   cfg_we                 cfg_index, cfg_data
//
// One byte per cycle while the output is not stalled: an item gives 4 bytes, 8 with one frame flag, 12 with both.
// The byte position counter of the item register sets that figure.
// The next item loads in the cycle its predecessor's last byte moves to the output.
// Reset clears valid flags and restores the config registers to 0, 0, 256.
// A stalled output holds its byte; the item register then holds as well.
// ----------------------------------------------------------------------------
module apa102_led_frame_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
	input  logic        s_axis_tuser,   // first_led
	input  logic        s_axis_tlast,   // last_led
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // out_byte
	output logic        m_axis_tlast,   // last_of_run
	output logic        m_axis_tuser    // frame_done
);

`include "apa102_led_frame_encoder_core_assert.svh"

	logic                color_order_q;
	logic                brightness_mode_q;
	logic [8:0]          global_brightness_q;

	logic                valid_s1;
	apa_enc_pkg::pos_t   pos_s1;
	apa_enc_pkg::led_t   led_s1;

	logic                m_valid_q;
	logic [7:0]          m_data_q;
	logic                m_last_q;
	logic                m_user_q;

	logic                in_accept;
	logic                advance;
	logic                last_byte;
	logic [7:0]          cur_byte;
	logic [4:0]          bright;

	assign advance   = valid_s1 && (!m_valid_q || m_axis_tready);
	assign last_byte = (pos_s1 == (led_s1.last_led ? apa_enc_pkg::POS_END3
		: apa_enc_pkg::POS_COLOR2));
	assign s_axis_tready = !valid_s1 || (advance && last_byte);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign bright = apa_enc_pkg::brightness(brightness_mode_q, global_brightness_q,
		led_s1.alpha);

	always_comb begin
		case (pos_s1)
			apa_enc_pkg::POS_START0, apa_enc_pkg::POS_START1,
			apa_enc_pkg::POS_START2, apa_enc_pkg::POS_START3: begin
				cur_byte = apa_enc_pkg::BYTE_START;
			end
			apa_enc_pkg::POS_HEADER: begin
				cur_byte = apa_enc_pkg::HEADER_MARK | {3'b000, bright};
			end
			apa_enc_pkg::POS_COLOR0: begin
				cur_byte = color_order_q ? led_s1.red : led_s1.blue;
			end
			apa_enc_pkg::POS_COLOR1: begin
				cur_byte = color_order_q ? led_s1.blue : led_s1.green;
			end
			apa_enc_pkg::POS_COLOR2: begin
				cur_byte = color_order_q ? led_s1.green : led_s1.red;
			end
			apa_enc_pkg::POS_END0, apa_enc_pkg::POS_END1,
			apa_enc_pkg::POS_END2, apa_enc_pkg::POS_END3: begin
				cur_byte = apa_enc_pkg::BYTE_END;
			end
			default: begin
				cur_byte = apa_enc_pkg::BYTE_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_order_q       <= 1'b0;
			brightness_mode_q   <= 1'b0;
			global_brightness_q <= apa_enc_pkg::GLOBAL_BRIGHTNESS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				apa_enc_pkg::CFG_COLOR_ORDER:       color_order_q       <= cfg_data[0];
				apa_enc_pkg::CFG_BRIGHTNESS_MODE:   brightness_mode_q   <= cfg_data[0];
				apa_enc_pkg::CFG_GLOBAL_BRIGHTNESS: global_brightness_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item register: load, step through bytes, drop after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_s1   <= apa_enc_pkg::POS_START0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
			pos_s1   <= s_axis_tuser ? apa_enc_pkg::POS_START0 : apa_enc_pkg::POS_HEADER;
		end else if (advance && last_byte) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			pos_s1 <= pos_s1 + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			led_s1.red      <= s_axis_tdata[7:0];
			led_s1.green    <= s_axis_tdata[15:8];
			led_s1.blue     <= s_axis_tdata[23:16];
			led_s1.alpha    <= s_axis_tdata[31:24];
			led_s1.last_led <= s_axis_tlast;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= cur_byte;
			m_last_q <= last_byte;
			m_user_q <= (pos_s1 == apa_enc_pkg::POS_END3);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_user_q;

	`APA_ASSERT_IMP(a_done_is_last, m_valid_q && m_user_q, m_last_q, "frame done without end of item")
	`APA_ASSERT_IMP(a_done_byte, m_valid_q && m_user_q, m_data_q == apa_enc_pkg::BYTE_END, "frame done on non-end byte")
	`APA_ASSERT_IMP(a_pos_range, valid_s1, pos_s1 <= apa_enc_pkg::POS_END3, "byte position out of range")
	`APA_ASSERT_NXT(a_load_pos, in_accept, valid_s1 && (pos_s1 == apa_enc_pkg::POS_START0 || pos_s1 == apa_enc_pkg::POS_HEADER), "bad start position")

endmodule
